// ===== src/m3i_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_pkg
// Shared types, widths and tables for the 3x3 fixed-point matrix inverter.
// ---------------------------------------------------------------------------
package m3i_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_DEF   = 16;
  localparam int CFG_WIDTH  = 32;
  localparam int NUM_ELEM   = 9;
  localparam int COF_WIDTH  = 2 * DATA_WIDTH + 1;
  localparam int DET_WIDTH  = 3 * DATA_WIDTH + 3;
  localparam int QUO_WIDTH  = DATA_WIDTH + 1;
  localparam int FRONT_LAT  = 5;
  localparam int LATENCY    = FRONT_LAT + QUO_WIDTH + 2;
  localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = CFG_WIDTH'(1);

  // adjugate element k = m[p]*m[q] - m[s]*m[t]
  localparam logic [3:0] COF_IDX [NUM_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] r00;
    logic signed [DATA_WIDTH-1:0] r01;
    logic signed [DATA_WIDTH-1:0] r02;
    logic signed [DATA_WIDTH-1:0] r10;
    logic signed [DATA_WIDTH-1:0] r11;
    logic signed [DATA_WIDTH-1:0] r12;
    logic signed [DATA_WIDTH-1:0] r20;
    logic signed [DATA_WIDTH-1:0] r21;
    logic signed [DATA_WIDTH-1:0] r22;
    logic                         singular;
    logic                         saturated;
  } result_t;

endpackage

// ===== src/matrix3_inverse_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix3_inverse_top
// 3x3 signed fixed-point matrix inverse through the adjugate.
// ---------------------------------------------------------------------------
// Input: matrix (nine elements row by row) is taken at a clock edge with
//   start high and busy low. busy is high only during reset, so one matrix
//   can enter every cycle.
// Output: result holds the inverse plus singular and saturated flags and is
//   valid for exactly one cycle while done is high; it is not held.
// Pipeline: five stages for cofactors and determinant, one overflow-check
//   stage and one stage per quotient bit in each of nine divider lanes,
//   one merge stage.
// Throughput: one matrix per cycle; nine lanes divide side by side.
// Config: cfg_data is written into the singular limit on a cfg_valid and
//   cfg_ready transfer; cfg_ready is always high. Write only when idle.
// Reset: synchronous rst clears all in-flight work and sets the limit to 1.
// ---------------------------------------------------------------------------
module matrix3_inverse_top #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  m3i_pkg::matrix_t              matrix,
  output logic                          done,
  output m3i_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [m3i_pkg::CFG_WIDTH-1:0] cfg_data
);
  import m3i_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int QB = QUO_WIDTH;
  localparam logic [QB-1:0] MAXP = QB'({1'b0, {(W-1){1'b1}}});

  logic [CFG_WIDTH-1:0]  limit;
  logic [LATENCY-2:0]    valid_sr;
  logic [QB:0]           sing_sr;
  logic [COF_WIDTH-1:0]  cof_mag [NUM_ELEM];
  logic [NUM_ELEM-1:0]   lane_neg;
  logic [DET_WIDTH-1:0]  det_mag;
  logic                  singular;
  logic [QB-1:0]         q_mag   [NUM_ELEM];
  logic [NUM_ELEM-1:0]   q_big;
  logic [NUM_ELEM-1:0]   q_neg;
  logic signed [W-1:0]   r_val   [NUM_ELEM];
  logic [NUM_ELEM-1:0]   r_sat;
  result_t               result_next;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit    <= LIMIT_RESET;
      valid_sr <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      valid_sr <= {valid_sr[LATENCY-3:0], start && !busy};
      done     <= valid_sr[LATENCY-2];
    end
  end

  m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .matrix   (matrix),
    .limit    (limit),
    .cof_mag  (cof_mag),
    .lane_neg (lane_neg),
    .det_mag  (det_mag),
    .singular (singular)
  );

  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
    m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .num_mag (cof_mag[k]),
      .den     (det_mag),
      .neg_in  (lane_neg[k]),
      .q_mag   (q_mag[k]),
      .big     (q_big[k]),
      .neg     (q_neg[k])
    );
  end

  always_ff @(posedge clk) begin
    sing_sr <= {sing_sr[QB-1:0], singular};
  end

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      r_sat[k] = q_big[k] || (!q_neg[k] && q_mag[k] > MAXP)
              || (q_neg[k] && q_mag[k] > MAXP + QB'(1));
      if (r_sat[k]) begin
        r_val[k] = q_neg[k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        r_val[k] = q_neg[k] ? W'(-q_mag[k]) : W'(q_mag[k]);
      end
      if (sing_sr[QB]) begin
        r_val[k] = '0;
        r_sat[k] = 1'b0;
      end
    end
    result_next.r00       = r_val[0];
    result_next.r01       = r_val[1];
    result_next.r02       = r_val[2];
    result_next.r10       = r_val[3];
    result_next.r11       = r_val[4];
    result_next.r12       = r_val[5];
    result_next.r20       = r_val[6];
    result_next.r21       = r_val[7];
    result_next.r22       = r_val[8];
    result_next.singular  = sing_sr[QB];
    result_next.saturated = |r_sat;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ===== src/m3i_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_front
// Cofactors, exact determinant, singular test and sign/magnitude split.
// ---------------------------------------------------------------------------
module m3i_front #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_DEF
) (
  input  logic                              clk,
  input  m3i_pkg::matrix_t                  matrix,
  input  logic [m3i_pkg::CFG_WIDTH-1:0]     limit,
  output logic [m3i_pkg::COF_WIDTH-1:0]     cof_mag [m3i_pkg::NUM_ELEM],
  output logic [m3i_pkg::NUM_ELEM-1:0]      lane_neg,
  output logic [m3i_pkg::DET_WIDTH-1:0]     det_mag,
  output logic                              singular
);
  import m3i_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int RW = CFG_WIDTH + 2 * FRAC_BITS;
  localparam int LW = (DET_WIDTH > RW ? DET_WIDTH : RW) + 1;

  logic signed [W-1:0]         m      [NUM_ELEM];
  logic signed [2*W-1:0]       pa     [NUM_ELEM];
  logic signed [2*W-1:0]       pb     [NUM_ELEM];
  logic signed [W-1:0]         m1     [3];
  logic signed [W-1:0]         m2     [3];
  logic signed [COF_WIDTH-1:0] cof2   [NUM_ELEM];
  logic signed [COF_WIDTH-1:0] cof3   [NUM_ELEM];
  logic signed [COF_WIDTH-1:0] cof4   [NUM_ELEM];
  logic signed [COF_WIDTH-1:0] lo     [3];
  logic signed [COF_WIDTH-1:0] hi     [3];
  logic signed [DET_WIDTH-1:0] det4;
  logic [DET_WIDTH-1:0]        det_abs;
  logic [LW-1:0]               lhs;
  logic [LW-1:0]               rhs;
  logic                        sing_next;

  assign m[0] = matrix.m00;
  assign m[1] = matrix.m01;
  assign m[2] = matrix.m02;
  assign m[3] = matrix.m10;
  assign m[4] = matrix.m11;
  assign m[5] = matrix.m12;
  assign m[6] = matrix.m20;
  assign m[7] = matrix.m21;
  assign m[8] = matrix.m22;

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      pa[k]   <= m[COF_IDX[k][0]] * m[COF_IDX[k][1]];
      pb[k]   <= m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
      cof2[k] <= COF_WIDTH'(pa[k]) - COF_WIDTH'(pb[k]);
      cof3[k] <= cof2[k];
      cof4[k] <= cof3[k];
    end
    for (int j = 0; j < 3; j++) begin
      m1[j] <= m[j];
      m2[j] <= m1[j];
      lo[j] <= m2[j] * $signed({1'b0, cof2[3*j][W-1:0]});
      hi[j] <= m2[j] * $signed(cof2[3*j][COF_WIDTH-1:W]);
    end
    det4 <= ((DET_WIDTH'(hi[0]) <<< W) + DET_WIDTH'(lo[0]))
          + ((DET_WIDTH'(hi[1]) <<< W) + DET_WIDTH'(lo[1]))
          + ((DET_WIDTH'(hi[2]) <<< W) + DET_WIDTH'(lo[2]));
  end

  always_comb begin
    det_abs   = det4[DET_WIDTH-1] ? DET_WIDTH'(-det4) : DET_WIDTH'(det4);
    lhs       = LW'(det_abs) + (LW'(1) << (2 * FRAC_BITS - 1));
    rhs       = LW'(limit) << (2 * FRAC_BITS);
    sing_next = (det4 == '0) || (lhs < rhs);
  end

  always_ff @(posedge clk) begin
    det_mag  <= det_abs;
    singular <= sing_next;
    for (int k = 0; k < NUM_ELEM; k++) begin
      cof_mag[k]  <= cof4[k][COF_WIDTH-1] ? COF_WIDTH'(-cof4[k]) : COF_WIDTH'(cof4[k]);
      lane_neg[k] <= cof4[k][COF_WIDTH-1] ^ det4[DET_WIDTH-1];
    end
  end

endmodule

// ===== src/m3i_div_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_div_lane
// Staged restoring divider: one quotient bit per stage plus overflow check.
// ---------------------------------------------------------------------------
module m3i_div_lane #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_DEF
) (
  input  logic                          clk,
  input  logic [m3i_pkg::COF_WIDTH-1:0] num_mag,
  input  logic [m3i_pkg::DET_WIDTH-1:0] den,
  input  logic                          neg_in,
  output logic [m3i_pkg::QUO_WIDTH-1:0] q_mag,
  output logic                          big,
  output logic                          neg
);
  import m3i_pkg::*;

  localparam int QB = QUO_WIDTH;
  localparam int NW = COF_WIDTH + 2 * FRAC_BITS;
  localparam int XW = (NW > DET_WIDTH + QB ? NW : DET_WIDTH + QB) + 1;

  logic [XW-1:0]        rem_r [QB];
  logic [DET_WIDTH-1:0] den_r [QB];
  logic [QB-1:0]        q_r   [QB+1];
  logic                 big_r [QB+1];
  logic                 neg_r [QB+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= XW'(num_mag) << (2 * FRAC_BITS);
    den_r[0] <= den;
    q_r[0]   <= '0;
    big_r[0] <= (XW'(num_mag) << (2 * FRAC_BITS)) >= (XW'(den) << QB);
    neg_r[0] <= neg_in;
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int B = QB - j;
    logic [XW-1:0] trial;
    logic          fits;

    always_comb begin
      trial = XW'(den_r[j-1]) << B;
      fits  = rem_r[j-1] >= trial;
    end

    always_ff @(posedge clk) begin
      q_r[j]   <= q_r[j-1] | (fits ? (QB'(1) << B) : '0);
      big_r[j] <= big_r[j-1];
      neg_r[j] <= neg_r[j-1];
    end

    if (j < QB) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[j] <= fits ? rem_r[j-1] - trial : rem_r[j-1];
        den_r[j] <= den_r[j-1];
      end
    end
  end

  assign q_mag = q_r[QB];
  assign big   = big_r[QB];
  assign neg   = neg_r[QB];

endmodule

// ===== src/m3i_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3i_checker
// Port-level checks on the matrix inverter, bound to the top level.
// ---------------------------------------------------------------------------
module m3i_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input m3i_pkg::result_t              result
);
  import m3i_pkg::*;

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without matching transfer");

  a_transfer_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("transfer produced no result");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.singular) |-> (!result.saturated && result.r00 == '0
      && result.r11 == '0 && result.r22 == '0))
    else $error("singular result not cleared");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done after reset");

endmodule

bind matrix3_inverse_top m3i_checker u_m3i_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
